>>> rtl/ffa_pkg.sv
// Shared constants, codes and types of the first-fit offset allocator.
// No dependencies; imported by ffa_size_align and first_fit_offset_allocator_core.
package ffa_pkg;

   localparam int FREE_ENTRIES_DEF = 16;
   localparam int OFFSET_BITS_DEF  = 32;

   localparam int LEN_W   = 32;          // length field width
   localparam int SIZE_W  = LEN_W + 1;   // aligned length, may carry out
   localparam int SHIFT_W = 3;           // align_shift register width
   localparam int OUT_W   = 32;          // result fields width

   localparam int REQ_W = 72;            // 65 payload bits padded to bytes
   localparam int RSP_W = 136;           // 130 payload bits padded to bytes

   localparam logic [SHIFT_W-1:0] ALIGN_RESET = 3'd3;
   localparam logic [SHIFT_W-1:0] ALIGN_MAX   = 3'd6;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_LEAKED   = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

endpackage

>>> rtl/first_fit_offset_allocator_core.sv
// Sequence: an overflow or a zero-length free is answered straight from decode; an allocation
// may scan the table, remove the chosen entry and reinsert a split remainder; the response then
// waits on rsp_tready.
// Throughput: one transaction at a time; the table read is registered, so each table entry
// visit passes a read state before its check or write state, and the scan/shift sets the rate.
// Reset (synchronous, active high): empty free table, heap end, used and peak cleared,
// alignment shift 3. The free table memory is not cleared; entries beyond the count are
// never read.
module first_fit_offset_allocator_core #(
   parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES_DEF,
   parameter int OFFSET_BITS  = ffa_pkg::OFFSET_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request: [0] command, [32:1] offset, [64:33] length, rest zero
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ffa_pkg::REQ_W-1:0]    req_tdata,
   // response: [31:0] granted_offset, [63:32] used_bytes, [95:64] peak_bytes,
   // [127:96] heap_top, [129:128] status, rest zero
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ffa_pkg::RSP_W-1:0]    rsp_tdata,
   // alignment shift register write
   input  logic                         csr_wen,
   input  logic [ffa_pkg::SHIFT_W-1:0]  csr_wdata
);
   import ffa_pkg::*;

   localparam int OB = OFFSET_BITS;
   localparam int CW = $clog2(FREE_ENTRIES + 1);   // counts 0..FREE_ENTRIES
   localparam int AW = $clog2(FREE_ENTRIES);       // table address
   localparam int XW = OB + SIZE_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_A_RD, S_A_CHK, S_A_HEAP, S_RM_RD, S_RM_WR,
      S_RS_START, S_RS_SIZE, S_IN_RD, S_IN_CHK, S_PLACE, S_F_MP, S_F_MN,
      S_MG1, S_MG2, S_MN_WR, S_INS, S_UP_RD, S_UP_WR, S_DONE
   } state_type;

   state_type state_ff;

   // free table memory, (start, size) per entry, kept sorted by start
   logic [OB-1:0] start_mem [FREE_ENTRIES];
   logic [OB-1:0] size_mem  [FREE_ENTRIES];
   logic [OB-1:0] rd_start_ff, rd_size_ff;
   logic [CW-1:0] rd_idx;
   logic          wr_en;
   logic [CW-1:0] wr_idx;
   logic [OB-1:0] wr_start, wr_size;

   logic [SHIFT_W-1:0] align_ff;
   logic               cmd_ff, ovf_ff, rem_ff, mp_ff, mn_ff, have_cur_ff;
   logic [OB-1:0]      addr_ff, size_ff, heap_ff, used_ff, peak_ff, granted_ff;
   logic [OB-1:0]      ins_start_ff, ins_size_ff, bs_ff, bz_ff, tmp_ff;
   logic [OB-1:0]      prev_start_ff, prev_size_ff, cur_start_ff, cur_size_ff;
   logic [CW-1:0]      idx_ff, pos_ff, count_ff;
   status_type         status_ff;

   // request unpack and alignment
   logic              req_cmd;
   logic [LEN_W-1:0]  req_offset, req_length;
   logic [SIZE_W-1:0] req_size;
   logic [XW-1:0]     req_size_x;

   assign req_cmd    = req_tdata[0];
   assign req_offset = req_tdata[32:1];
   assign req_length = req_tdata[64:33];

   ffa_size_align u_align (
      .length (req_length),
      .shift  (align_ff),
      .size   (req_size)
   );

   assign req_size_x = XW'(req_size);

   // shared adder/subtractor: operands chosen by the sequencer state
   logic [OB-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [OB:0]   alu_sum;

   always_comb begin
      alu_a   = addr_ff;
      alu_b   = size_ff;
      alu_sub = 1'b0;
      case (state_ff)
         S_A_HEAP:   alu_a = heap_ff;
         S_RS_START: alu_a = bs_ff;
         S_RS_SIZE: begin
            alu_a   = bz_ff;
            alu_sub = 1'b1;
         end
         S_F_MP: begin
            alu_a = prev_start_ff;
            alu_b = prev_size_ff;
         end
         S_MG1:      alu_a = prev_size_ff;
         S_MG2: begin
            alu_a = tmp_ff;
            alu_b = cur_size_ff;
         end
         S_MN_WR:    alu_a = cur_size_ff;
         default:    alu_a = addr_ff;
      endcase
   end

   assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                            : ({1'b0, alu_a} + {1'b0, alu_b});

   // saturating usage counters
   logic [OB:0]   used_sum;
   logic [OB-1:0] used_add, used_sub, peak_in;

   assign used_sum = {1'b0, used_ff} + {1'b0, size_ff};
   assign used_add = used_sum[OB] ? {OB{1'b1}} : used_sum[OB-1:0];
   assign used_sub = (used_ff >= size_ff) ? (used_ff - size_ff) : '0;
   assign peak_in  = (used_add > peak_ff) ? used_add : peak_ff;

   // table read address and write port, steered by state
   always_comb begin
      rd_idx   = idx_ff;
      wr_en    = 1'b0;
      wr_idx   = idx_ff;
      wr_start = rd_start_ff;
      wr_size  = rd_size_ff;
      case (state_ff)
         S_RM_RD: rd_idx = idx_ff + CW'(1);
         S_UP_RD: begin
            rd_idx = idx_ff - CW'(1);
            if (idx_ff <= pos_ff) begin
               wr_en    = 1'b1;
               wr_idx   = pos_ff;
               wr_start = ins_start_ff;
               wr_size  = ins_size_ff;
            end
         end
         S_RM_WR, S_UP_WR: wr_en = 1'b1;
         S_MG1: begin
            wr_en    = !mn_ff;
            wr_idx   = pos_ff - CW'(1);
            wr_start = prev_start_ff;
            wr_size  = alu_sum[OB-1:0];
         end
         S_MG2: begin
            wr_en    = 1'b1;
            wr_idx   = pos_ff - CW'(1);
            wr_start = prev_start_ff;
            wr_size  = alu_sum[OB-1:0];
         end
         S_MN_WR: begin
            wr_en    = 1'b1;
            wr_idx   = pos_ff;
            wr_start = addr_ff;
            wr_size  = alu_sum[OB-1:0];
         end
         default: rd_idx = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx[AW-1:0]] <= wr_start;
         size_mem[wr_idx[AW-1:0]]  <= wr_size;
      end
      rd_start_ff <= start_mem[rd_idx[AW-1:0]];
      rd_size_ff  <= size_mem[rd_idx[AW-1:0]];
   end

   // alignment register
   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff <= ALIGN_RESET;
      end else if (csr_wen) begin
         align_ff <= csr_wdata;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         heap_ff  <= '0;
         used_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_cmd;
                  addr_ff  <= OB'(req_offset);
                  size_ff  <= req_size_x[OB-1:0];
                  ovf_ff   <= |(req_size_x >> OB);
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               granted_ff <= '0;
               status_ff  <= ST_OK;
               idx_ff     <= '0;
               if (ovf_ff) begin
                  status_ff <= ST_OVERFLOW;
                  state_ff  <= S_DONE;
               end else if (cmd_ff == CMD_ALLOC) begin
                  state_ff <= (count_ff == '0) ? S_A_HEAP : S_A_RD;
               end else if (size_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  used_ff <= used_sub;
                  // a free ending at the heap end pulls the heap end back
                  if (alu_sum == {1'b0, heap_ff}) begin
                     heap_ff  <= addr_ff;
                     state_ff <= S_DONE;
                  end else begin
                     ins_start_ff <= addr_ff;
                     ins_size_ff  <= size_ff;
                     state_ff     <= S_IN_RD;
                  end
               end
            end
            S_A_RD: state_ff <= S_A_CHK;
            S_A_CHK: begin
               if (rd_size_ff >= size_ff) begin
                  // first fit: take it, split off the remainder later
                  granted_ff <= rd_start_ff;
                  bs_ff      <= rd_start_ff;
                  bz_ff      <= rd_size_ff;
                  rem_ff     <= rd_size_ff > size_ff;
                  used_ff    <= used_add;
                  peak_ff    <= peak_in;
                  state_ff   <= S_RM_RD;
               end else if (idx_ff + CW'(1) == count_ff) begin
                  state_ff <= S_A_HEAP;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_A_RD;
               end
            end
            S_A_HEAP: begin
               if (alu_sum[OB]) begin
                  status_ff <= ST_OVERFLOW;
               end else begin
                  granted_ff <= heap_ff;
                  heap_ff    <= alu_sum[OB-1:0];
                  used_ff    <= used_add;
                  peak_ff    <= peak_in;
               end
               state_ff <= S_DONE;
            end
            S_RM_RD: begin
               if (idx_ff + CW'(1) < count_ff) begin
                  state_ff <= S_RM_WR;
               end else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= (cmd_ff == CMD_ALLOC && rem_ff) ? S_RS_START : S_DONE;
               end
            end
            S_RM_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_RM_RD;
            end
            S_RS_START: begin
               ins_start_ff <= alu_sum[OB-1:0];
               state_ff     <= S_RS_SIZE;
            end
            S_RS_SIZE: begin
               ins_size_ff <= alu_sum[OB-1:0];
               idx_ff      <= '0;
               state_ff    <= S_IN_RD;
            end
            S_IN_RD: begin
               if (idx_ff == count_ff) begin
                  pos_ff      <= idx_ff;
                  have_cur_ff <= 1'b0;
                  state_ff    <= S_PLACE;
               end else begin
                  state_ff <= S_IN_CHK;
               end
            end
            S_IN_CHK: begin
               if (rd_start_ff < ins_start_ff) begin
                  prev_start_ff <= rd_start_ff;
                  prev_size_ff  <= rd_size_ff;
                  idx_ff        <= idx_ff + CW'(1);
                  state_ff      <= S_IN_RD;
               end else if (rd_start_ff == ins_start_ff) begin
                  // same start already free: leave the table alone
                  state_ff <= S_DONE;
               end else begin
                  pos_ff       <= idx_ff;
                  have_cur_ff  <= 1'b1;
                  cur_start_ff <= rd_start_ff;
                  cur_size_ff  <= rd_size_ff;
                  state_ff     <= S_PLACE;
               end
            end
            S_PLACE: state_ff <= (cmd_ff == CMD_FREE) ? S_F_MP : S_INS;
            S_F_MP: begin
               mp_ff    <= (pos_ff != '0) && (alu_sum == {1'b0, addr_ff});
               state_ff <= S_F_MN;
            end
            S_F_MN: begin
               mn_ff <= have_cur_ff && (alu_sum == {1'b0, cur_start_ff});
               if (mp_ff) begin
                  state_ff <= S_MG1;
               end else if (have_cur_ff && (alu_sum == {1'b0, cur_start_ff})) begin
                  state_ff <= S_MN_WR;
               end else begin
                  state_ff <= S_INS;
               end
            end
            S_MG1: begin
               tmp_ff   <= alu_sum[OB-1:0];
               idx_ff   <= pos_ff;
               state_ff <= mn_ff ? S_MG2 : S_DONE;
            end
            S_MG2:   state_ff <= S_RM_RD;   // drop the successor it absorbed
            S_MN_WR: state_ff <= S_DONE;
            S_INS: begin
               if (count_ff == FULL_COUNT) begin
                  if (cmd_ff == CMD_FREE) begin
                     status_ff <= ST_LEAKED;
                  end
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= count_ff;
                  state_ff <= S_UP_RD;
               end
            end
            S_UP_RD: begin
               if (idx_ff > pos_ff) begin
                  state_ff <= S_UP_WR;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_UP_WR: begin
               idx_ff   <= idx_ff - CW'(1);
               state_ff <= S_UP_RD;
            end
            S_DONE: begin
               if (rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {6'd0, status_ff, OUT_W'(heap_ff), OUT_W'(peak_ff),
                        OUT_W'(used_ff), OUT_W'(granted_ff)};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("free entry count above table depth");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a response is pending");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      used_ff <= peak_ff)
      else $error("used bytes above peak");

   a_done_exit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("sequencer did not return to idle after response");
`endif

endmodule

>>> rtl/ffa_size_align.sv
// Rounds a byte length up to the alignment granule (2**shift, shift capped).
// Depends on ffa_pkg.
module ffa_size_align (
   input  logic [ffa_pkg::LEN_W-1:0]   length,
   input  logic [ffa_pkg::SHIFT_W-1:0] shift,
   output logic [ffa_pkg::SIZE_W-1:0]  size
);
   import ffa_pkg::*;

   logic [SHIFT_W-1:0] sh;
   logic [SIZE_W-1:0]  gmask;

   assign sh    = (shift > ALIGN_MAX) ? ALIGN_MAX : shift;
   assign gmask = (SIZE_W'(1) << sh) - SIZE_W'(1);
   assign size  = (SIZE_W'(length) + gmask) & ~gmask;

endmodule

>>> tb/first_fit_offset_allocator_core_test.sv
// Self-checking testbench for first_fit_offset_allocator_core: directed and random
// allocate/free traffic against a behavioral allocator model. Depends on ffa_pkg.
module first_fit_offset_allocator_core_test;
   import ffa_pkg::*;

   localparam int ENTRIES = FREE_ENTRIES_DEF;
   localparam longint LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [SHIFT_W-1:0] csr_wdata = '0;

   always #4 clock = ~clock;

   first_fit_offset_allocator_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [31:0] granted;
      logic [31:0] used;
      logic [31:0] peak;
      logic [31:0] top;
      status_type  status;
   } alloc_result_t;

   // allocator model state, all widths in 64 bits with 32-bit wrap where needed
   longint unsigned blk_base[ENTRIES];
   longint unsigned blk_len[ENTRIES];
   int unsigned     blk_count;
   longint unsigned heap_end_m, used_m, peak_m;
   logic [SHIFT_W-1:0] shift_m;

   alloc_result_t expected_q[$];
   longint        cycle_count = 0;
   int            mismatches = 0;
   int            stall_left = 0;
   bit            quiet = 1'b0;        // no idling in the final stretch
   // live allocations, so frees in the random part are mostly well-formed
   logic [31:0]   live_base[$];
   logic [31:0]   live_len[$];

   localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

   function automatic void table_drop(int unsigned i);
      for (int unsigned k = i; k + 1 < blk_count; k++) begin
         blk_base[k] = blk_base[k+1];
         blk_len[k]  = blk_len[k+1];
      end
      blk_count--;
   endfunction

   function automatic bit table_add(longint unsigned b, longint unsigned l);
      int unsigned p;
      p = 0;
      while (p < blk_count && blk_base[p] < b) p++;
      if (p < blk_count && blk_base[p] == b) return 1'b0;
      if (blk_count >= ENTRIES) return 1'b0;
      for (int unsigned k = blk_count; k > p; k--) begin
         blk_base[k] = blk_base[k-1];
         blk_len[k]  = blk_len[k-1];
      end
      blk_base[p] = b;
      blk_len[p]  = l;
      blk_count++;
      return 1'b1;
   endfunction

   function automatic void grow_used(longint unsigned l);
      longint unsigned s;
      s = used_m + l;
      used_m = (s > MASK32) ? MASK32 : s;
      if (used_m > peak_m) peak_m = used_m;
   endfunction

   // compute the response for one request and update the model
   function automatic alloc_result_t predict_allocation(logic cmd, logic [31:0] off,
                                                        logic [31:0] len);
      alloc_result_t r;
      int unsigned sh, i, p;
      longint unsigned gmask, sz, addr, bs, bz;
      bit found, dup, mp, mn;
      r = '0;
      r.status = ST_OK;
      sh = 32'((shift_m > ALIGN_MAX) ? ALIGN_MAX : shift_m);
      gmask = (64'd1 << sh) - 1;
      sz = (64'(len) + gmask) & ~gmask;
      addr = 64'(off);
      if (sz > MASK32) begin
         r.status = ST_OVERFLOW;
      end else if (cmd == CMD_ALLOC) begin
         found = 1'b0;
         for (i = 0; i < blk_count; i++) if (blk_len[i] >= sz) begin
            found = 1'b1;
            break;
         end
         if (found) begin
            bs = blk_base[i];
            bz = blk_len[i];
            r.granted = bs[31:0];
            table_drop(i);
            if (bz > sz) void'(table_add((bs + sz) & MASK32, bz - sz));
            grow_used(sz);
         end else if (heap_end_m + sz > MASK32) begin
            r.status = ST_OVERFLOW;
         end else begin
            r.granted = heap_end_m[31:0];
            heap_end_m += sz;
            grow_used(sz);
         end
      end else if (sz != 0) begin
         used_m = (used_m >= sz) ? used_m - sz : 0;
         if (addr + sz == heap_end_m) begin
            heap_end_m = addr;
         end else begin
            p = 0;
            while (p < blk_count && blk_base[p] < addr) p++;
            dup = p < blk_count && blk_base[p] == addr;
            if (!dup) begin
               mp = p > 0 && (blk_base[p-1] + blk_len[p-1] == addr);
               mn = p < blk_count && (addr + sz == blk_base[p]);
               if (mp && mn) begin
                  blk_len[p-1] = (blk_len[p-1] + sz + blk_len[p]) & MASK32;
                  table_drop(p);
               end else if (mp) begin
                  blk_len[p-1] = (blk_len[p-1] + sz) & MASK32;
               end else if (mn) begin
                  blk_base[p] = addr;
                  blk_len[p]  = (blk_len[p] + sz) & MASK32;
               end else if (!table_add(addr, sz)) begin
                  r.status = ST_LEAKED;
               end
            end
         end
      end
      r.used = used_m[31:0];
      r.peak = peak_m[31:0];
      r.top  = heap_end_m[31:0];
      return r;
   endfunction

   task automatic idle_cycles();
      if (!quiet && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(posedge clock);
   endtask

   // send one request transaction and queue its expected response
   task automatic send_request(logic cmd, logic [31:0] off, logic [31:0] len);
      alloc_result_t r;
      idle_cycles();
      req_tdata  <= {7'b0, len, off, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = predict_allocation(cmd, off, len);
      expected_q.push_back(r);
      if (cmd == CMD_ALLOC && r.status == ST_OK && len != 0) begin
         live_base.push_back(r.granted);
         live_len.push_back(len);
      end
      req_tvalid <= 1'b0;
      // the core is busy after a transaction anyway
      @(posedge clock);
   endtask

   // wait until every response has come back, then let the core settle
   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_align(logic [SHIFT_W-1:0] v);
      drain();
      csr_wdata <= v;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      shift_m = v;
   endtask

   // response checker: hold rsp_tready low in random bursts, compare each transaction
   always @(posedge clock) begin
      alloc_result_t got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                 rsp_tdata[127:96], rsp_tdata[129:128]};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h got %h", want, got);
            end
         end
      end
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= int'($urandom_range(1, 10));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) if (cycle_count > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
   end

   // edge cases: zero lengths, overflow, duplicate and unmatched frees, heap pullback
   task automatic test_directed();
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_request(CMD_FREE, 32'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 32'd0, 32'd13);
      send_request(CMD_ALLOC, 32'd0, 32'd8);
      send_request(CMD_ALLOC, 32'd0, 32'd100);
      send_request(CMD_FREE, 32'd0, 32'd13);
      send_request(CMD_FREE, 32'd0, 32'd13);
      send_request(CMD_FREE, 32'd16, 32'd8);
      send_request(CMD_ALLOC, 32'd0, 32'd0);
      send_request(CMD_ALLOC, 32'd0, 32'd5);
      send_request(CMD_FREE, 32'd24, 32'd104);
      send_request(CMD_FREE, 32'd4000, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 32'd0, 32'hF000_0000);
      send_request(CMD_ALLOC, 32'd0, 32'h2000_0000);
      send_request(CMD_FREE, 32'hFFFF_FFF0, 32'd16);
      send_request(CMD_FREE, 32'd0, 32'hF000_0000);
      send_request(CMD_ALLOC, 32'd0, 32'hEFFF_FFF9);
   endtask

   // fill the free table past its size to make frees leak
   task automatic test_table_full();
      for (int i = 0; i < 20; i++) send_request(CMD_ALLOC, 32'd0, 32'd64);
      for (int i = 0; i < 20; i += 2) send_request(CMD_FREE, live_base[i], 32'd64);
      for (int i = 0; i < 40; i++) send_request(CMD_FREE, 32'h0010_0000 + i * 256, 32'd64);
   endtask

   // mostly allocate/free pairs of live ranges, some noise frees and huge lengths
   task automatic test_random(int n);
      int k, sel;
      logic [31:0] len;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45 || live_base.size() == 0) begin
            len = (sel < 3) ? $urandom : $urandom_range(0, 300);
            send_request(CMD_ALLOC, $urandom, len);
         end else if (sel < 90) begin
            k = $urandom_range(0, live_base.size() - 1);
            send_request(CMD_FREE, live_base[k], live_len[k]);
            live_base.delete(k);
            live_len.delete(k);
         end else begin
            send_request(1'($urandom_range(0, 1)), $urandom,
                         (sel < 95) ? $urandom : $urandom_range(0, 64));
         end
      end
   endtask

   initial begin
      shift_m = ALIGN_RESET;
      blk_count = 0;
      heap_end_m = 0;
      used_m = 0;
      peak_m = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      write_align(3'd0);
      test_random(350);
      write_align(3'd7);
      test_random(350);
      write_align(3'd6);
      test_random(350);
      write_align(3'd2);
      test_random(350);
      quiet = 1'b1;
      test_random(250);
      drain();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
